FILE: hdl/tccs_pkg.sv
package tccs_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  localparam int ADDR_W = $clog2(CELLS);
  localparam int IDX_W  = 11;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;

  localparam int LAST_ROW_BASE = CELLS - COLUMNS;

  localparam logic [1:0] MODE_PRINT = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  localparam logic [CELL_W-1:0] CELL_BLANK = {8'h00, CH_SPACE};

  // Memory port request driven by the controller
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Finished result handed to the output register
  typedef struct packed {
    logic             load;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } res_t;

endpackage

FILE: hdl/tccs_ram.sv
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/tccs_ctrl.sv
module tccs_ctrl
  import tccs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  logic [7:0]        in_char_code,
  input  logic [3:0]        in_fg_color,
  input  logic [3:0]        in_bg_color,
  input  logic [IDX_W-1:0]  in_cell_index,
  output mem_req_t          mem_req,
  input  logic [CELL_W-1:0] mem_rdata,
  input  logic              out_free,
  output res_t              res
);

  localparam logic [2:0] ST_FILL = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_SCR  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(LAST_ROW_BASE);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic              cp_v_r, cp_v_nxt;
  logic [ADDR_W-1:0] cp_addr_r, cp_addr_nxt;
  logic              fill_blank_r, fill_blank_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [7:0]        pend_char_r, pend_char_nxt;
  logic [7:0]        pend_attr_r, pend_attr_nxt;

  logic              do_nl;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    cp_v_nxt       = 1'b0;
    cp_addr_nxt    = cp_addr_r;
    fill_blank_nxt = fill_blank_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    base_nxt       = base_r;
    pend_char_nxt  = pend_char_r;
    pend_attr_nxt  = pend_attr_r;
    do_nl          = 1'b0;
    mem_req        = '0;
    res            = '0;
    res.cell_char  = pend_char_r;
    res.cell_attr  = pend_attr_r;
    res.row        = row_r;
    res.col        = col_r;

    case (state_r)
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = fill_blank_r ? CELL_BLANK : '0;
        if (ptr_r == LAST_ADDR) begin
          ptr_nxt   = '0;
          state_nxt = fill_blank_r ? ST_FIN : ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          pend_char_nxt = '0;
          pend_attr_nxt = '0;
          state_nxt     = ST_FIN;
          case (in_mode)
            MODE_PRINT: begin
              if (in_char_code == CH_NEWLINE) begin
                do_nl = 1'b1;
              end else if (in_char_code != CH_NUL) begin
                mem_req.we    = 1'b1;
                mem_req.waddr = base_r + ADDR_W'(col_r);
                mem_req.wdata = {in_bg_color, in_fg_color, in_char_code};
                if (col_r == LAST_COL) begin
                  do_nl = 1'b1;
                end else begin
                  col_nxt = col_r + 1'b1;
                end
              end
            end
            MODE_CLEAR: begin
              row_nxt        = '0;
              col_nxt        = '0;
              base_nxt       = '0;
              ptr_nxt        = '0;
              fill_blank_nxt = 1'b1;
              state_nxt      = ST_FILL;
            end
            MODE_READ: begin
              if ({1'b0, in_cell_index} < (IDX_W + 1)'(CELLS)) begin
                mem_req.re    = 1'b1;
                mem_req.raddr = ADDR_W'(in_cell_index);
                state_nxt     = ST_RD;
              end
            end
            default: begin
            end
          endcase
          if (do_nl) begin
            col_nxt = '0;
            if (row_r == LAST_ROW) begin
              ptr_nxt   = '0;
              state_nxt = ST_SCR;
            end else begin
              row_nxt  = row_r + 1'b1;
              base_nxt = base_r + ROW_STEP;
            end
          end
        end
      end

      ST_RD: begin
        pend_char_nxt = mem_rdata[7:0];
        pend_attr_nxt = mem_rdata[15:8];
        state_nxt     = ST_FIN;
      end

      // Scroll sweep: read one row ahead, write it back in the next cycle; then blank the last row.
      ST_SCR: begin
        if (cp_v_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cp_addr_r;
          mem_req.wdata = mem_rdata;
        end
        if (ptr_r < LAST_BASE) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ptr_r + ROW_STEP;
          cp_v_nxt      = 1'b1;
          cp_addr_nxt   = ptr_r;
          ptr_nxt       = ptr_r + 1'b1;
        end else if (!cp_v_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ptr_r;
          mem_req.wdata = CELL_BLANK;
          if (ptr_r == LAST_ADDR) begin
            ptr_nxt   = '0;
            state_nxt = ST_FIN;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          res.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_FILL;
      ptr_r        <= '0;
      cp_v_r       <= 1'b0;
      fill_blank_r <= 1'b0;
      row_r        <= '0;
      col_r        <= '0;
      base_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      cp_v_r       <= cp_v_nxt;
      fill_blank_r <= fill_blank_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      base_r       <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r   <= cp_addr_nxt;
    pend_char_r <= pend_char_nxt;
    pend_attr_r <= pend_attr_nxt;
  end

endmodule

FILE: hdl/text_console_cursor_scroll_top.sv
// Print, newline without scroll and ignored codes go from ST_IDLE straight to ST_FIN; a read passes ST_RD between.
// Scroll: a sweep through the single RAM write port copies each row up, then blanks the last row.
// Clear: a sweep writes a blank to every cell, one cell written per cycle.
// One beat is in flight at a time; the output register lets the next beat in while a result waits.
// Reset (rst_n low, synchronous): cursor homed, then a pass over every cell zeroes the cell RAM;
// in_stall stays high until that pass is done.
module text_console_cursor_scroll_top
  import tccs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_mode,
  input  logic [7:0]       in_char_code,
  input  logic [3:0]       in_fg_color,
  input  logic [3:0]       in_bg_color,
  input  logic [IDX_W-1:0] in_cell_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_cell_char,
  output logic [7:0]       out_cell_attr,
  output logic [ROW_W-1:0] out_cursor_row_out,
  output logic [COL_W-1:0] out_cursor_col_out
);

  mem_req_t          mem_req;
  logic [CELL_W-1:0] mem_rdata;
  res_t              res;
  logic              out_free;

  logic              out_valid_r;
  logic [7:0]        out_char_r;
  logic [7:0]        out_attr_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;

  // Cell store: char in low byte, attribute in high byte, linear address row*COLUMNS+col
  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Cursor, command decode, scroll/clear sweeps
  tccs_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_char_code  (in_char_code),
    .in_fg_color   (in_fg_color),
    .in_bg_color   (in_bg_color),
    .in_cell_index (in_cell_index),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata),
    .out_free      (out_free),
    .res           (res)
  );

  // Output register: free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_char_r <= res.cell_char;
      out_attr_r <= res.cell_attr;
      out_row_r  <= res.row;
      out_col_r  <= res.col;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_cell_char      = out_char_r;
  assign out_cell_attr      = out_attr_r;
  assign out_cursor_row_out = out_row_r;
  assign out_cursor_col_out = out_col_r;

endmodule
